// ===== sv/hng_pkg.sv =====
// Package for the heightmap normal generator.
// Field widths, fixed-point constants, sequencer states and the control struct.
// No dependencies.
package hng_pkg;

   localparam int COORD_W    = 8;
   localparam int COLOR_W    = 8;
   localparam int SUM_W      = 10;
   localparam int SCALE_W    = 16;
   localparam int MAPW_W     = 9;
   localparam int NX_W       = 16;
   localparam int NY_W       = 15;
   localparam int MAG_W      = 26;
   localparam int PROD_W     = 2 * MAG_W;
   localparam int DIFF_W     = MAG_W + 1;
   localparam int SQ_W       = PROD_W + 1;
   localparam int ACC_W      = 64;
   localparam int LEN_W      = 32;
   localparam int QUOT_W     = 16;
   localparam int CNT_W      = 5;
   localparam int SEL_W      = 2;
   localparam int ROOT_STEPS = 32;
   localparam int FRAC_SHIFT = 20;
   localparam int ROOT_SHIFT = 10;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_MAP_WIDTH    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT_SCALE = 1'b1;

   localparam logic [MAPW_W-1:0]  MAPW_RESET  = 9'd256;
   localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // upward term 2.0 in Q.8 and its square
   localparam logic [MAG_W-1:0] DY_Q8 = 26'd512;
   localparam logic [SQ_W-1:0]  DY_SQ = 53'd262144;

   localparam logic [QUOT_W-1:0] SAT_POS = 16'd32767;
   localparam logic [QUOT_W:0]   SAT_NEG = 17'd32768;

   localparam logic [SEL_W-1:0] NB_UP    = 2'd0;
   localparam logic [SEL_W-1:0] NB_DOWN  = 2'd1;
   localparam logic [SEL_W-1:0] NB_LEFT  = 2'd2;
   localparam logic [SEL_W-1:0] NB_RIGHT = 2'd3;
   localparam logic [SEL_W-1:0] NB_LAST  = 2'd3;

   localparam logic [SEL_W-1:0] COMP_X    = 2'd0;
   localparam logic [SEL_W-1:0] COMP_Y    = 2'd1;
   localparam logic [SEL_W-1:0] COMP_Z    = 2'd2;
   localparam logic [SEL_W-1:0] COMP_LAST = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_ADDR,
      ST_RD_MUL,
      ST_RD_ACC,
      ST_SQ_X,
      ST_SQ_Z,
      ST_SQ_SUM,
      ST_ROOT_INIT,
      ST_ROOT,
      ST_DIV_INIT,
      ST_DIV,
      ST_DIV_STORE,
      ST_OUT
   } state_type;

   typedef struct packed {
      state_type          step;
      logic [SEL_W-1:0]   sel;
      logic               load_wr;
      logic               query_start;
      logic               out_load;
   } hng_ctrl_type;

endpackage

// ===== sv/hng_req_if.sv =====
// Request channel: valid/ready handshake with load or query payload.
// Depends on hng_pkg.
interface hng_req_if import hng_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               operation;
   logic [COORD_W-1:0] row;
   logic [COORD_W-1:0] column;
   logic [COLOR_W-1:0] red;
   logic [COLOR_W-1:0] green;
   logic [COLOR_W-1:0] blue;

   modport source (output valid, operation, row, column, red, green, blue, input ready);
   modport sink   (input valid, operation, row, column, red, green, blue, output ready);
endinterface

// ===== sv/hng_rsp_if.sv =====
// Response channel: valid/ready handshake carrying the unit normal.
// Depends on hng_pkg.
interface hng_rsp_if import hng_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic signed [NX_W-1:0] normal_x;
   logic        [NY_W-1:0] normal_y;
   logic signed [NX_W-1:0] normal_z;

   modport source (output valid, normal_x, normal_y, normal_z, input ready);
   modport sink   (input valid, normal_x, normal_y, normal_z, output ready);
endinterface

// ===== sv/hng_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hng_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/hng_seq.sv =====
// Sequencer: walks one transaction through neighbor reads, root and divisions.
// Depends on hng_pkg.
module hng_seq import hng_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_op,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output hng_ctrl_type ctrl
);

   state_type        state_ff, state_in;
   logic [SEL_W-1:0] sel_ff, sel_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             load_wr, query_start, out_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sel_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      sel_in      = sel_ff;
      cnt_in      = cnt_ff;
      load_wr     = 1'b0;
      query_start = 1'b0;
      out_load    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_op == OP_QUERY) begin
                  query_start = 1'b1;
                  sel_in      = NB_UP;
                  state_in    = ST_RD_ADDR;
               end else begin
                  load_wr = 1'b1;
               end
            end
         end
         ST_RD_ADDR: state_in = ST_RD_MUL;
         ST_RD_MUL:  state_in = ST_RD_ACC;
         ST_RD_ACC: begin
            if (sel_ff == NB_LAST) begin
               state_in = ST_SQ_X;
            end else begin
               sel_in   = sel_ff + 1'b1;
               state_in = ST_RD_ADDR;
            end
         end
         ST_SQ_X:   state_in = ST_SQ_Z;
         ST_SQ_Z:   state_in = ST_SQ_SUM;
         ST_SQ_SUM: state_in = ST_ROOT_INIT;
         ST_ROOT_INIT: begin
            cnt_in   = CNT_W'(ROOT_STEPS - 1);
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (cnt_ff == '0) begin
               sel_in   = COMP_X;
               state_in = ST_DIV_INIT;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_DIV_INIT: begin
            cnt_in   = CNT_W'(QUOT_W - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (cnt_ff == '0) begin
               state_in = ST_DIV_STORE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_DIV_STORE: begin
            if (sel_ff == COMP_LAST) begin
               state_in = ST_OUT;
            end else begin
               sel_in   = sel_ff + 1'b1;
               state_in = ST_DIV_INIT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign ctrl.step        = state_ff;
   assign ctrl.sel         = sel_ff;
   assign ctrl.load_wr     = load_wr;
   assign ctrl.query_start = query_start;
   assign ctrl.out_load    = out_load;

endmodule

// ===== sv/hng_dp.sv =====
// Datapath: height store, shared multiplier and shared 64-bit subtract/compare unit.
// Depends on hng_pkg and hng_ram.
module hng_dp import hng_pkg::*; #(
   parameter int SIDE_MAX = 256
) (
   input  logic                clock,
   input  hng_ctrl_type        ctrl,
   input  logic [COORD_W-1:0]  req_row,
   input  logic [COORD_W-1:0]  req_column,
   input  logic [COLOR_W-1:0]  req_red,
   input  logic [COLOR_W-1:0]  req_green,
   input  logic [COLOR_W-1:0]  req_blue,
   input  logic [MAPW_W-1:0]   map_width,
   input  logic [SCALE_W-1:0]  height_scale,
   output logic [NX_W-1:0]     normal_x,
   output logic [NY_W-1:0]     normal_y,
   output logic [NX_W-1:0]     normal_z
);

   localparam int CW       = $clog2(SIDE_MAX);
   localparam int AW       = 2 * CW;
   localparam int DEPTH    = 2 ** AW;
   localparam int SIDE_CAP = (SIDE_MAX < 511) ? SIDE_MAX : 511;
   localparam int NB_W     = COORD_W + 2;

   logic [COORD_W-1:0] row_ff, row_in, col_ff, col_in;
   logic               in_map_ff, in_map_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [DIFF_W-1:0]  dx_ff, dx_in, dz_ff, dz_in;
   logic [SQ_W-1:0]    s_ff, s_in;
   logic [ACC_W-1:0]   v_ff, v_in, res_ff, res_in, bit_ff, bit_in;
   logic [ACC_W-1:0]   rem_ff, rem_in, dsh_ff, dsh_in;
   logic [QUOT_W-1:0]  quo_ff, quo_in;
   logic [NX_W-1:0]    nx_ff, nx_in, nz_ff, nz_in;
   logic [NY_W-1:0]    ny_ff, ny_in;
   logic [NX_W-1:0]    out_x_ff, out_z_ff;
   logic [NY_W-1:0]    out_y_ff;

   logic [MAPW_W-1:0]  w_eff;
   logic [NB_W-1:0]    row_ext, col_ext, nr, nc;
   logic               nb_in_map, store_hit;
   logic [AW-1:0]      rd_addr, wr_addr;
   logic [SUM_W-1:0]   wr_data, mem_q;

   logic [MAG_W-1:0]   mul_a, mul_b;
   logic [PROD_W-1:0]  mul_p;
   logic [ACC_W-1:0]   sub_a, sub_b;
   logic [ACC_W:0]     sub_diff;
   logic               sub_ge;

   logic [DIFF_W-1:0]  dx_abs, dz_abs, p_ext;
   logic [MAG_W-1:0]   dx_mag, dz_mag, comp_mag;
   logic               comp_neg;
   logic [QUOT_W-1:0]  q_pos;
   logic [QUOT_W:0]    q_neg_mag, q_neg;
   logic [NX_W-1:0]    comp_val;

   // neighbor addressing
   assign w_eff   = (map_width < MAPW_W'(SIDE_CAP)) ? map_width : MAPW_W'(SIDE_CAP);
   assign row_ext = {2'b00, row_ff};
   assign col_ext = {2'b00, col_ff};

   always_comb begin
      nr = row_ext;
      nc = col_ext;
      unique case (ctrl.sel)
         NB_UP:    nr = row_ext - NB_W'(1);
         NB_DOWN:  nr = row_ext + NB_W'(1);
         NB_LEFT:  nc = col_ext - NB_W'(1);
         NB_RIGHT: nc = col_ext + NB_W'(1);
      endcase
   end

   assign nb_in_map = !nr[NB_W-1] && !nc[NB_W-1]
                      && (nr[COORD_W:0] < w_eff) && (nc[COORD_W:0] < w_eff);
   assign rd_addr   = {CW'(nr[COORD_W:0]), CW'(nc[COORD_W:0])};
   assign store_hit = (int'(req_row) < SIDE_MAX) && (int'(req_column) < SIDE_MAX);
   assign wr_addr   = {CW'(req_row), CW'(req_column)};
   assign wr_data   = SUM_W'(req_red) + SUM_W'(req_green) + SUM_W'(req_blue);

   hng_ram #(
      .WIDTH (SUM_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ctrl.load_wr && store_hit),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (ctrl.step == ST_RD_ADDR),
      .rd_addr (rd_addr),
      .rd_data (mem_q)
   );

   // magnitudes and component select
   assign dx_abs = dx_ff[DIFF_W-1] ? (DIFF_W'(0) - dx_ff) : dx_ff;
   assign dz_abs = dz_ff[DIFF_W-1] ? (DIFF_W'(0) - dz_ff) : dz_ff;
   assign dx_mag = dx_abs[MAG_W-1:0];
   assign dz_mag = dz_abs[MAG_W-1:0];
   assign p_ext  = DIFF_W'(prod_ff[MAG_W-1:0]);

   always_comb begin
      comp_mag = DY_Q8;
      comp_neg = 1'b0;
      unique case (ctrl.sel)
         COMP_X: begin
            comp_mag = dx_mag;
            comp_neg = dx_ff[DIFF_W-1];
         end
         COMP_Z: begin
            comp_mag = dz_mag;
            comp_neg = dz_ff[DIFF_W-1];
         end
         default: begin
            comp_mag = DY_Q8;
            comp_neg = 1'b0;
         end
      endcase
   end

   // shared multiplier
   always_comb begin
      mul_a = dz_mag;
      mul_b = dz_mag;
      if (ctrl.step == ST_RD_MUL) begin
         mul_a = in_map_ff ? MAG_W'(mem_q) : '0;
         mul_b = MAG_W'(height_scale);
      end else if (ctrl.step == ST_SQ_X) begin
         mul_a = dx_mag;
         mul_b = dx_mag;
      end
   end

   assign mul_p = mul_a * mul_b;

   // shared subtract/compare unit
   always_comb begin
      sub_a = rem_ff;
      sub_b = dsh_ff;
      if (ctrl.step == ST_ROOT) begin
         sub_a = v_ff;
         sub_b = res_ff | bit_ff;
      end
   end

   assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
   assign sub_ge   = !sub_diff[ACC_W];

   // rounding result saturation
   assign q_pos     = (quo_ff > SAT_POS) ? SAT_POS : quo_ff;
   assign q_neg_mag = ({1'b0, quo_ff} > SAT_NEG) ? SAT_NEG : {1'b0, quo_ff};
   assign q_neg     = (QUOT_W+1)'(0) - q_neg_mag;
   assign comp_val  = comp_neg ? q_neg[NX_W-1:0] : q_pos;

   always_comb begin
      row_in    = row_ff;
      col_in    = col_ff;
      in_map_in = in_map_ff;
      prod_in   = mul_p;
      dx_in     = dx_ff;
      dz_in     = dz_ff;
      s_in      = s_ff;
      v_in      = v_ff;
      res_in    = res_ff;
      bit_in    = bit_ff;
      rem_in    = rem_ff;
      dsh_in    = dsh_ff;
      quo_in    = quo_ff;
      nx_in     = nx_ff;
      ny_in     = ny_ff;
      nz_in     = nz_ff;
      unique case (ctrl.step)
         ST_IDLE: begin
            if (ctrl.query_start) begin
               row_in = req_row;
               col_in = req_column;
               dx_in  = '0;
               dz_in  = '0;
            end
         end
         ST_RD_ADDR: in_map_in = nb_in_map;
         ST_RD_ACC: begin
            unique case (ctrl.sel)
               NB_UP:    dx_in = dx_ff + p_ext;
               NB_DOWN:  dx_in = dx_ff - p_ext;
               NB_LEFT:  dz_in = dz_ff + p_ext;
               NB_RIGHT: dz_in = dz_ff - p_ext;
            endcase
         end
         ST_SQ_Z:   s_in = DY_SQ + SQ_W'(prod_ff);
         ST_SQ_SUM: s_in = s_ff + SQ_W'(prod_ff);
         ST_ROOT_INIT: begin
            v_in   = ACC_W'(s_ff) << ROOT_SHIFT;
            res_in = '0;
            bit_in = ACC_W'(1) << (ACC_W - 2);
         end
         ST_ROOT: begin
            if (sub_ge) begin
               v_in   = sub_diff[ACC_W-1:0];
               res_in = (res_ff >> 1) | bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
         end
         ST_DIV_INIT: begin
            rem_in = (ACC_W'(comp_mag) << FRAC_SHIFT) + ACC_W'(res_ff[LEN_W-1:1]);
            dsh_in = ACC_W'(res_ff[LEN_W-1:0]) << (QUOT_W - 1);
            quo_in = '0;
         end
         ST_DIV: begin
            if (sub_ge) begin
               rem_in = sub_diff[ACC_W-1:0];
            end
            quo_in = {quo_ff[QUOT_W-2:0], sub_ge};
            dsh_in = dsh_ff >> 1;
         end
         ST_DIV_STORE: begin
            unique case (ctrl.sel)
               COMP_X:  nx_in = comp_val;
               COMP_Y:  ny_in = q_pos[NY_W-1:0];
               COMP_Z:  nz_in = comp_val;
               default: nz_in = nz_ff;
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      row_ff    <= row_in;
      col_ff    <= col_in;
      in_map_ff <= in_map_in;
      prod_ff   <= prod_in;
      dx_ff     <= dx_in;
      dz_ff     <= dz_in;
      s_ff      <= s_in;
      v_ff      <= v_in;
      res_ff    <= res_in;
      bit_ff    <= bit_in;
      rem_ff    <= rem_in;
      dsh_ff    <= dsh_in;
      quo_ff    <= quo_in;
      nx_ff     <= nx_in;
      ny_ff     <= ny_in;
      nz_ff     <= nz_in;
      if (ctrl.out_load) begin
         out_x_ff <= nx_ff;
         out_y_ff <= ny_ff;
         out_z_ff <= nz_ff;
      end
   end

   assign normal_x = out_x_ff;
   assign normal_y = out_y_ff;
   assign normal_z = out_z_ff;

endmodule

// ===== sv/heightmap_normal_generator.sv =====
// Heightmap normal generator top level: CSRs, sequencer and datapath.
// A load is written on acceptance and leaves the block ready. A query holds the block
// through the four neighbor reads, squaring, the root and three divisions on the shared
// 64-bit subtractor, and until the response register is free for its result.
// Synchronous reset clears the sequencer and response valid and sets map_width and
// height_scale to 256; the height store is not cleared.
module heightmap_normal_generator import hng_pkg::*; #(
   parameter int SIDE_MAX = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   hng_req_if.sink               req_bus,
   hng_rsp_if.source             rsp_bus,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [MAPW_W-1:0]  map_width_ff, map_width_in;
   logic [SCALE_W-1:0] scale_ff, scale_in;
   hng_ctrl_type       ctrl;
   logic [NX_W-1:0]    normal_x, normal_z;
   logic [NY_W-1:0]    normal_y;

   always_comb begin
      map_width_in = map_width_ff;
      scale_in     = scale_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MAP_WIDTH:    map_width_in = csr_wdata[MAPW_W-1:0];
            CSR_HEIGHT_SCALE: scale_in     = csr_wdata[SCALE_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff <= MAPW_RESET;
         scale_ff     <= SCALE_RESET;
      end else begin
         map_width_ff <= map_width_in;
         scale_ff     <= scale_in;
      end
   end

   hng_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_op    (req_bus.operation),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .ctrl      (ctrl)
   );

   hng_dp #(
      .SIDE_MAX (SIDE_MAX)
   ) u_dp (
      .clock        (clock),
      .ctrl         (ctrl),
      .req_row      (req_bus.row),
      .req_column   (req_bus.column),
      .req_red      (req_bus.red),
      .req_green    (req_bus.green),
      .req_blue     (req_bus.blue),
      .map_width    (map_width_ff),
      .height_scale (scale_ff),
      .normal_x     (normal_x),
      .normal_y     (normal_y),
      .normal_z     (normal_z)
   );

   assign rsp_bus.normal_x = normal_x;
   assign rsp_bus.normal_y = normal_y;
   assign rsp_bus.normal_z = normal_z;

endmodule

// ===== dv/tb_heightmap_normal_generator.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for heightmap_normal_generator: loads and queries in random bursts,
// normals predicted per transaction and compared field by field in order of arrival.
// Depends on hng_pkg, hng_req_if, hng_rsp_if and the top level under sv/.
module tb_heightmap_normal_generator import hng_pkg::*; ();

   localparam int SIDE        = 256;
   localparam int DRAIN_CYCLES = 120;
   localparam int TARGET_ITEMS = 1850;

   typedef struct packed {
      logic               operation;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] column;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } height_cmd_type;

   typedef struct packed {
      logic signed [NX_W-1:0] x;
      logic        [NY_W-1:0] y;
      logic signed [NX_W-1:0] z;
   } normal_type;

   typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE} rx_mode_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   hng_req_if req_bus ();
   hng_rsp_if rsp_bus ();

   heightmap_normal_generator #(.SIDE_MAX(SIDE)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predicted state and configuration
   bit   [SUM_W-1:0]   heights [SIDE*SIDE];
   logic [MAPW_W-1:0]  cfg_width = MAPW_RESET;
   logic [SCALE_W-1:0] cfg_scale = SCALE_RESET;

   // stimulus bookkeeping
   bit             loaded_gen [SIDE*SIDE];
   int             gen_eff = SIDE;
   height_cmd_type cmd_fifo [$];
   normal_type     expected_normals [$];
   int             n_pushed = 0;
   int             n_accepted = 0;
   int             n_results = 0;
   int             errors = 0;

   int          burst_left;
   int          gap_left;
   rx_mode_type rx_mode;
   int          rx_left;
   logic [1:0]  rx_tick;
   int          hold_left;
   int          holds_started;

   function automatic int eff_width(input int width);
      return (width > SIDE) ? SIDE : width;
   endfunction

   function automatic longint signed height_at(input int r, input int c);
      int eff;
      longint unsigned h;
      eff = eff_width(int'(cfg_width));
      if (r < 0 || c < 0 || r >= eff || c >= eff)
         return 0;
      h = heights[r*SIDE + c];
      return longint'(h * cfg_scale);
   endfunction

   function automatic longint unsigned root_floor(input longint unsigned v);
      longint unsigned res;
      longint unsigned rem;
      longint unsigned probe;
      res = 0;
      rem = v;
      probe = 64'h4000_0000_0000_0000;
      while (probe > rem)
         probe = probe >> 2;
      while (probe != 0) begin
         if (rem >= res + probe) begin
            rem = rem - (res + probe);
            res = (res >> 1) + probe;
         end else begin
            res = res >> 1;
         end
         probe = probe >> 2;
      end
      return res;
   endfunction

   function automatic int unit_component(input longint signed c, input longint unsigned len);
      longint unsigned mag;
      longint unsigned q;
      mag = (c < 0) ? -c : c;
      q = ((mag << FRAC_SHIFT) + (len >> 1)) / len;
      if (c < 0) begin
         if (q > SAT_NEG)
            q = SAT_NEG;
         return -int'(q);
      end
      if (q > SAT_POS)
         q = SAT_POS;
      return int'(q);
   endfunction

   function automatic normal_type predict_normal(input logic [COORD_W-1:0] r,
                                                 input logic [COORD_W-1:0] c);
      int ri;
      int ci;
      longint signed dx;
      longint signed dz;
      longint unsigned sq;
      longint unsigned len;
      normal_type n;
      ri = int'(r);
      ci = int'(c);
      dx = height_at(ri - 1, ci) - height_at(ri + 1, ci);
      dz = height_at(ri, ci - 1) - height_at(ri, ci + 1);
      sq = dx*dx + dz*dz + longint'(DY_Q8) * longint'(DY_Q8);
      len = root_floor(sq << ROOT_SHIFT);
      n.x = NX_W'(unit_component(dx, len));
      n.y = NY_W'(unit_component(longint'(DY_Q8), len));
      n.z = NX_W'(unit_component(dz, len));
      return n;
   endfunction

   function automatic logic [COLOR_W-1:0] rand_color();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return COLOR_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic int pick_coord();
      if (gen_eff == 0 || $urandom_range(0, 9) == 0)
         return $urandom_range(0, SIDE-1);
      return $urandom_range(0, (gen_eff >= SIDE) ? SIDE-1 : gen_eff);
   endfunction

   task automatic push_load(input int r, input int c, input logic [COLOR_W-1:0] red,
                            input logic [COLOR_W-1:0] green, input logic [COLOR_W-1:0] blue);
      height_cmd_type cmd;
      cmd = '{operation: OP_LOAD, row: COORD_W'(r), column: COORD_W'(c),
              red: red, green: green, blue: blue};
      cmd_fifo = {cmd_fifo, cmd};
      loaded_gen[r*SIDE + c] = 1'b1;
      n_pushed++;
   endtask

   // load any in-map neighbor that was never written, then query
   task automatic push_query(input int r, input int c);
      int nr [4];
      int nc [4];
      height_cmd_type cmd;
      nr = '{r-1, r+1, r, r};
      nc = '{c, c, c-1, c+1};
      for (int k = 0; k < 4; k++) begin
         if (nr[k] >= 0 && nc[k] >= 0 && nr[k] < gen_eff && nc[k] < gen_eff &&
             !loaded_gen[nr[k]*SIDE + nc[k]])
            push_load(nr[k], nc[k], rand_color(), rand_color(), rand_color());
      end
      cmd = '{operation: OP_QUERY, row: COORD_W'(r), column: COORD_W'(c),
              red: rand_color(), green: rand_color(), blue: rand_color()};
      cmd_fifo = {cmd_fifo, cmd};
      n_pushed++;
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_config(input int width, input int scale);
      write_csr(CSR_MAP_WIDTH, width);
      write_csr(CSR_HEIGHT_SCALE, scale);
      cfg_width = MAPW_W'(width);
      cfg_scale = SCALE_W'(scale);
      gen_eff = eff_width(width);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      while (!(n_accepted == n_pushed && expected_normals.size() == 0))
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic flag_mismatch(input string what, input longint want, input longint got);
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
   endtask

   // request driver: bursts of transactions separated by random gaps
   always @(posedge clock) begin : drive_req
      height_cmd_type cmd;
      int roll;
      if (reset) begin
         req_bus.valid <= 1'b0;
         burst_left <= 0;
         gap_left <= 0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (gap_left != 0) begin
            req_bus.valid <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (cmd_fifo.size() != 0) begin
            cmd = cmd_fifo.pop_front();
            req_bus.valid     <= 1'b1;
            req_bus.operation <= cmd.operation;
            req_bus.row       <= cmd.row;
            req_bus.column    <= cmd.column;
            req_bus.red       <= cmd.red;
            req_bus.green     <= cmd.green;
            req_bus.blue      <= cmd.blue;
            if (burst_left <= 1) begin
               roll = $urandom_range(0, 19);
               burst_left <= $urandom_range(1, 24);
               if (roll < 6)
                  gap_left <= 0;
               else if (roll < 18)
                  gap_left <= $urandom_range(1, 8);
               else
                  gap_left <= $urandom_range(20, 130);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // track accepted transactions and predict normals
   always @(posedge clock) begin : track_req
      if (!reset && req_bus.valid && req_bus.ready) begin
         n_accepted++;
         if (req_bus.operation == OP_LOAD)
            heights[{req_bus.row, req_bus.column}] =
               {2'b00, req_bus.red} + {2'b00, req_bus.green} + {2'b00, req_bus.blue};
         else
            expected_normals = {expected_normals,
                                predict_normal(req_bus.row, req_bus.column)};
      end
   end

   // long hold-off so the block backs up and stalls its input
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         holds_started <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (holds_started < 2 && n_results >= 40 + 400*holds_started) begin
         hold_left <= 900;
         holds_started <= holds_started + 1;
      end
   end

   // response ready pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rx_mode <= RX_OPEN;
         rx_left <= 0;
         rx_tick <= '0;
      end else begin
         if (rx_left == 0) begin
            rx_mode <= rx_mode_type'($urandom_range(0, 2));
            rx_left <= $urandom_range(50, 400);
         end else begin
            rx_left <= rx_left - 1;
         end
         rx_tick <= rx_tick + 2'd1;
         case (rx_mode)
            RX_OPEN: rsp_bus.ready <= (hold_left == 0);
            RX_COIN: rsp_bus.ready <= (hold_left == 0) && ($urandom_range(0, 1) == 1);
            default: rsp_bus.ready <= (hold_left == 0) && (rx_tick == 2'b00);
         endcase
      end
   end

   // response monitor
   always @(posedge clock) begin : check_rsp
      normal_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         n_results <= n_results + 1;
         if (expected_normals.size() == 0) begin
            errors++;
            $display("%0t: unexpected normal: expected none, actual %0d %0d %0d", $time,
                     rsp_bus.normal_x, rsp_bus.normal_y, rsp_bus.normal_z);
         end else begin
            want = expected_normals.pop_front();
            if (rsp_bus.normal_x !== want.x)
               flag_mismatch("normal_x", want.x, rsp_bus.normal_x);
            if (rsp_bus.normal_y !== want.y)
               flag_mismatch("normal_y", want.y, rsp_bus.normal_y);
            if (rsp_bus.normal_z !== want.z)
               flag_mismatch("normal_z", want.z, rsp_bus.normal_z);
         end
      end
   end

   initial begin : stimulus
      int phase_items;
      int roll;
      int width;
      int scale;
      req_bus.valid = 1'b0;
      req_bus.operation = OP_LOAD;
      req_bus.row = '0;
      req_bus.column = '0;
      req_bus.red = '0;
      req_bus.green = '0;
      req_bus.blue = '0;
      rsp_bus.ready = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // corners, edges and color extremes at the reset configuration
      push_load(1, 0, 8'hFF, 8'hFF, 8'hFF);
      push_load(0, 1, 8'h00, 8'h00, 8'h00);
      push_load(254, 255, 8'h80, 8'h7F, 8'h01);
      push_load(255, 254, 8'hFF, 8'h00, 8'hFF);
      push_query(0, 0);
      push_query(255, 255);
      push_query(0, 255);
      push_query(255, 0);
      push_query(128, 128);
      wait_idle();

      // zero map width: every neighbor is outside
      set_config(0, 65535);
      push_query(0, 0);
      push_query(77, 200);
      wait_idle();

      // width beyond the store, full scale: steep slopes saturate
      set_config(511, 65535);
      push_query(0, 0);
      push_query(255, 255);
      wait_idle();

      // single-entry map, zero scale, centers inside and outside the map
      set_config(1, 0);
      push_query(0, 0);
      push_query(0, 1);
      push_query(200, 3);
      wait_idle();

      while (n_pushed < TARGET_ITEMS) begin
         case ($urandom_range(0, 9))
            0: width = SIDE;
            1: width = $urandom_range(SIDE + 1, 511);
            2: width = $urandom_range(0, 1);
            3: width = SIDE - 1;
            default: width = $urandom_range(2, 24);
         endcase
         case ($urandom_range(0, 5))
            0: scale = 0;
            1: scale = 65535;
            2: scale = $urandom_range(0, 65535);
            default: scale = $urandom_range(1, 2048);
         endcase
         set_config(width, scale);
         phase_items = $urandom_range(120, 260);
         for (int k = 0; k < phase_items && n_pushed < TARGET_ITEMS; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 60 || gen_eff == 0)
               push_query(pick_coord(), pick_coord());
            else if (roll < 85)
               push_load(pick_coord(), pick_coord(), rand_color(), rand_color(),
                         rand_color());
            else
               push_load($urandom_range(0, SIDE-1), $urandom_range(0, SIDE-1),
                         COLOR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom));
         end
         wait_idle();
      end

      if (errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #30_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/hng_pkg.sv
sv/hng_req_if.sv
sv/hng_rsp_if.sv
sv/hng_ram.sv
sv/hng_seq.sv
sv/hng_dp.sv
sv/heightmap_normal_generator.sv
dv/tb_heightmap_normal_generator.sv
